### rtl/cv3_pkg.sv
// Shared types and constants of the 3x3 convolution filter core.
`default_nettype none

package cv3_pkg;

	localparam int PIX_W       = 8;
	localparam int WEIGHT_W    = 18;
	localparam int WROW_W      = 3 * WEIGHT_W;
	localparam int KSIZE       = 3;
	localparam int KK          = KSIZE * KSIZE;
	localparam int LW_W        = 12;
	localparam int FH_W        = 13;
	localparam int ROW_W       = 12;
	localparam int COL_OUT_W   = 11;
	localparam int PROD_W      = PIX_W + 1 + WEIGHT_W;
	localparam int SUM_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_HEIGHT  = 4096;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = 3;
	localparam int FIFO_CNT_W  = 4;

	localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
	localparam logic [WROW_W-1:0] ROW0_RESET = 54'd0;
	localparam logic [WROW_W-1:0] ROW1_RESET = 54'd1073741824;
	localparam logic [WROW_W-1:0] ROW2_RESET = 54'd0;
	localparam logic [LW_W-1:0]   LW_RESET   = 12'd640;
	localparam logic [FH_W-1:0]   FH_RESET   = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0     = 3'd0,
		CFG_ROW1     = 3'd1,
		CFG_ROW2     = 3'd2,
		CFG_WIDTH    = 3'd3,
		CFG_HEIGHT   = 3'd4,
		CFG_OVF_MODE = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OVF_CLAMP = 1'b0,
		OVF_WRAP  = 1'b1
	} ovf_mode_t;

	typedef logic [KK-1:0][PIX_W-1:0]     win_t;
	typedef logic [KSIZE-1:0][WROW_W-1:0] wrows_t;

	// Per-item side information that rides along the datapath
	typedef struct packed {
		logic                 vres;
		logic [ROW_W-1:0]     crow;
		logic [COL_OUT_W-1:0] ccol;
	} tag_t;

	typedef struct packed {
		logic [PIX_W-1:0]     pix;
		logic                 vres;
		logic [ROW_W-1:0]     crow;
		logic [COL_OUT_W-1:0] ccol;
	} result_t;

endpackage

`default_nettype wire

### rtl/cv3_if.sv
// Channel interfaces: pixel input, filter result output and configuration write.
`default_nettype none

interface cv3_pix_if import cv3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface cv3_res_if import cv3_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PIX_W-1:0]     filtered_pixel;
	logic                 valid_res;
	logic [ROW_W-1:0]     centre_row;
	logic [COL_OUT_W-1:0] centre_col;

	modport source (output valid, output filtered_pixel, output valid_res,
		output centre_row, output centre_col, input ready);
	modport sink (input valid, input filtered_pixel, input valid_res,
		input centre_row, input centre_col, output ready);
endinterface

interface cv3_cfg_if import cv3_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WROW_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/cv3_line_buf.sv
// Two-line pixel store with read-modify-write forwarding and the 3x3 window registers.
`default_nettype none

module cv3_line_buf import cv3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	input  wire logic [PIX_W-1:0]             px,
	input  wire tag_t                         tag,
	output      logic                         clearing,
	output      logic                         win_vld,
	output      win_t                         win,
	output      tag_t                         win_tag
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	// Entry layout: upper byte is the older line, lower byte the previous line
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	logic               v_s1;
	logic [COL_W-1:0]   col_s1;
	logic [PIX_W-1:0]   px_s1;
	tag_t               tag_s1;
	logic               fwd_s1;
	logic [2*PIX_W-1:0] fwd_q;
	logic [2*PIX_W-1:0] rd_data_q;
	logic [2*PIX_W-1:0] lines_s1;
	logic [2*PIX_W-1:0] wr_data;
	logic               clr_q;
	logic [COL_W-1:0]   clr_addr_q;
	win_t               win_q;
	logic               win_vld_q;
	tag_t               win_tag_q;

	assign lines_s1 = fwd_s1 ? fwd_q : rd_data_q;
	assign wr_data  = {lines_s1[PIX_W-1:0], px_s1};

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (v_s1) begin
			mem[col_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_col];
		end
	end

	// Zero the store after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			// Back-to-back hit on the entry being written: bypass the stale read
			fwd_s1 <= rd_en && v_s1 && (rd_col == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			col_s1 <= rd_col;
			px_s1  <= px;
			tag_s1 <= tag;
		end
		fwd_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			win_vld_q <= 1'b0;
		end else begin
			win_vld_q <= v_s1;
			if (v_s1) begin
				for (int r = 0; r < KSIZE; r++) begin
					win_q[r*KSIZE]     <= win_q[r*KSIZE + 1];
					win_q[r*KSIZE + 1] <= win_q[r*KSIZE + 2];
				end
				win_q[KSIZE-1]   <= lines_s1[2*PIX_W-1:PIX_W];
				win_q[2*KSIZE-1] <= lines_s1[PIX_W-1:0];
				win_q[KK-1]      <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_tag_q <= tag_s1;
		end
	end

	assign clearing = clr_q;
	assign win_vld  = win_vld_q;
	assign win      = win_q;
	assign win_tag  = win_tag_q;

endmodule

`default_nettype wire

### rtl/cv3_mac.sv
// Pipelined nine-tap multiply, adder tree, truncation and clamp or wrap of the result.
`default_nettype none

module cv3_mac import cv3_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_vld,
	input  wire win_t      win,
	input  wire tag_t      tag,
	input  wire wrows_t    wrows,
	input  wire ovf_mode_t mode,
	output      logic      out_vld,
	output      result_t   res
);

	logic signed [PROD_W-1:0] prod_d  [KK];
	logic signed [PROD_W-1:0] prod_s3 [KK];
	logic signed [SUM_W-1:0]  rsum_s4 [KSIZE];
	logic signed [SUM_W-1:0]  sum_s5;
	logic                     v_s3, v_s4, v_s5, v_s6;
	tag_t                     tag_s3, tag_s4, tag_s5;
	result_t                  res_s6;

	logic                 neg;
	logic [SUM_W-1:0]     mag;
	logic [SUM_W-1:0]     q;
	logic [PIX_W-1:0]     wrap_px;
	logic [PIX_W-1:0]     clamp_px;
	result_t              res_d;

	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			for (int c = 0; c < KSIZE; c++) begin
				prod_d[r*KSIZE + c] = $signed({1'b0, win[r*KSIZE + c]}) *
					$signed(wrows[r][c*WEIGHT_W +: WEIGHT_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= in_vld;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod_d;
		tag_s3  <= tag;
		for (int r = 0; r < KSIZE; r++) begin
			rsum_s4[r] <= SUM_W'(prod_s3[r*KSIZE]) + SUM_W'(prod_s3[r*KSIZE + 1]) +
				SUM_W'(prod_s3[r*KSIZE + 2]);
		end
		tag_s4 <= tag_s3;
		sum_s5 <= rsum_s4[0] + rsum_s4[1] + rsum_s4[2];
		tag_s5 <= tag_s4;
		res_s6 <= res_d;
	end

	// Truncate toward zero: shift the magnitude, then restore the sign
	always_comb begin
		neg      = sum_s5[SUM_W-1];
		mag      = neg ? (~sum_s5 + 1'b1) : sum_s5;
		q        = mag >> FRAC_BITS;
		wrap_px  = neg ? (~q[PIX_W-1:0] + 1'b1) : q[PIX_W-1:0];
		clamp_px = neg ? '0 : ((|q[SUM_W-1:PIX_W]) ? PIX_MAX : q[PIX_W-1:0]);
		res_d.vres = tag_s5.vres;
		res_d.crow = tag_s5.crow;
		res_d.ccol = tag_s5.ccol;
		if (!tag_s5.vres) begin
			res_d.pix = '0;
		end else if (mode == OVF_WRAP) begin
			res_d.pix = wrap_px;
		end else begin
			res_d.pix = clamp_px;
		end
	end

	assign out_vld = v_s6;
	assign res     = res_s6;

endmodule

`default_nettype wire

### rtl/cv3_out_fifo.sv
// Small result queue that decouples the free-running datapath from the receiver.
`default_nettype none

module cv3_out_fifo import cv3_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t wdata,
	input  wire logic    pop,
	output      logic    not_empty,
	output      result_t rdata
);

	result_t               store [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign rdata     = store[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/conv3x3_image_filter_core.sv
// Top level of the streaming 3x3 convolution filter: counters, registers, datapath glue.
//
// Pixels enter on the pixels channel in raster order, one transaction per pixel;
// frame_start on a pixel zeroes the row and column counters before that pixel.
// Every accepted pixel yields exactly one transaction on the results channel,
// describing the window centre one row up and one column left of it.
// Results come out in input order; one pixel per cycle is sustained while
// pixels.ready stays high, set by the single read and single write port of the
// line store used in every cycle.
// Registers are written on the cfg channel (always ready); the user must write
// them only while no pixel is in flight, which the block itself does not enforce.
// After reset the line store is zeroed, one column entry per cycle, over all
// MAX_WIDTH entries; pixels.ready stays low meanwhile.
// A stalled receiver fills an 8-entry result queue; pixels are still accepted
// until 8 results are outstanding, then pixels.ready drops until results drain.
`default_nettype none

module conv3x3_image_filter_core import cv3_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int FRAC_BITS = 12
) (
	input wire logic   clk,
	input wire logic   arst_n,
	cv3_pix_if.sink    pixels,
	cv3_res_if.source  results,
	cv3_cfg_if.sink    cfg
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

	wrows_t          wrows_q;
	logic [LW_W-1:0] line_width_q;
	logic [FH_W-1:0] frame_height_q;
	ovf_mode_t       mode_q;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [FIFO_CNT_W-1:0] occ_q;

	logic             in_acc;
	logic             out_acc;
	logic             clearing;
	logic [ROW_W-1:0] rc;
	logic [COL_W-1:0] cc;
	logic [WW-1:0]    lw_ext;
	logic [WW-1:0]    weff;
	logic [FH_W-1:0]  heff;
	logic             col_wrap;
	logic             row_wrap;
	tag_t             tag_in;

	logic    win_vld;
	win_t    win;
	tag_t    win_tag;
	logic    mac_vld;
	result_t mac_res;
	logic    q_not_empty;
	result_t q_head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrows_q[0]     <= ROW0_RESET;
			wrows_q[1]     <= ROW1_RESET;
			wrows_q[2]     <= ROW2_RESET;
			line_width_q   <= LW_RESET;
			frame_height_q <= FH_RESET;
			mode_q         <= OVF_CLAMP;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ROW0:     wrows_q[0]     <= cfg.data;
				CFG_ROW1:     wrows_q[1]     <= cfg.data;
				CFG_ROW2:     wrows_q[2]     <= cfg.data;
				CFG_WIDTH:    line_width_q   <= cfg.data[LW_W-1:0];
				CFG_HEIGHT:   frame_height_q <= cfg.data[FH_W-1:0];
				CFG_OVF_MODE: mode_q         <= ovf_mode_t'(cfg.data[0]);
				default:      ;
			endcase
		end
	end

	// Saturate the geometry into its legal range
	always_comb begin
		lw_ext = WW'(line_width_q);
		if (lw_ext < WW'(3)) begin
			weff = WW'(3);
		end else if (lw_ext > WW'(MAX_WIDTH)) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = lw_ext;
		end
		if (frame_height_q < FH_W'(3)) begin
			heff = FH_W'(3);
		end else if (frame_height_q > FH_W'(MAX_HEIGHT)) begin
			heff = FH_W'(MAX_HEIGHT);
		end else begin
			heff = frame_height_q;
		end
	end

	assign in_acc  = pixels.valid && pixels.ready;
	assign out_acc = results.valid && results.ready;
	assign pixels.ready = !clearing && (occ_q < FIFO_CNT_W'(FIFO_DEPTH));

	assign rc = pixels.frame_start ? '0 : row_q;
	assign cc = pixels.frame_start ? '0 : col_q;

	assign col_wrap = (WW'(cc) + WW'(1)) >= weff;
	assign row_wrap = (FH_W'(rc) + FH_W'(1)) >= heff;

	always_comb begin
		tag_in.vres = (rc >= ROW_W'(2)) && (cc >= COL_W'(2)) &&
			(FH_W'(rc) < heff) && (WW'(cc) < weff);
		tag_in.crow = (rc != '0) ? (rc - 1'b1) : '0;
		tag_in.ccol = (cc != '0) ? COL_OUT_W'(cc - 1'b1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : (rc + 1'b1);
			end else begin
				col_q <= cc + 1'b1;
				row_q <= rc;
			end
		end
	end

	// Outstanding transactions: accepted pixels whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	cv3_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_col   (cc),
		.px       (pixels.pixel),
		.tag      (tag_in),
		.clearing (clearing),
		.win_vld  (win_vld),
		.win      (win),
		.win_tag  (win_tag)
	);

	cv3_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (win_vld),
		.win     (win),
		.tag     (win_tag),
		.wrows   (wrows_q),
		.mode    (mode_q),
		.out_vld (mac_vld),
		.res     (mac_res)
	);

	cv3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mac_vld),
		.wdata     (mac_res),
		.pop       (results.ready),
		.not_empty (q_not_empty),
		.rdata     (q_head)
	);

	assign results.valid          = q_not_empty;
	assign results.filtered_pixel = q_head.pix;
	assign results.valid_res      = q_head.vres;
	assign results.centre_row     = q_head.crow;
	assign results.centre_col     = q_head.ccol;

endmodule

`default_nettype wire

### rtl/cv3_checker.sv
// Port-level checks of the convolution filter core and their binding to it.
`default_nettype none

module cv3_checker import cv3_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [PIX_W-1:0]     filtered_pixel,
	input wire logic                 valid_res,
	input wire logic [ROW_W-1:0]     centre_row,
	input wire logic [COL_OUT_W-1:0] centre_col
);

	logic [7:0] outstanding_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_pixel) &&
			$stable(valid_res) && $stable(centre_row) && $stable(centre_col))
		else $error("result changed while stalled");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> filtered_pixel == '0)
		else $error("invalid result carries a nonzero pixel");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> centre_row != '0 && centre_col != '0)
		else $error("valid result on a border centre");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> outstanding_q != '0)
		else $error("result delivered without an accepted pixel");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q >= 8'(FIFO_DEPTH) |-> !in_ready)
		else $error("pixel accepted beyond result queue capacity");

endmodule

bind conv3x3_image_filter_core cv3_checker u_cv3_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (pixels.valid),
	.in_ready       (pixels.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.filtered_pixel (results.filtered_pixel),
	.valid_res      (results.valid_res),
	.centre_row     (results.centre_row),
	.centre_col     (results.centre_col)
);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 convolution filter core with a cycle-free pixel predictor.
module tb;
	import cv3_pkg::*;

	localparam int MAX_W       = 2048;
	localparam int FRAC        = 12;
	localparam int RAND_ITEMS  = 300;
	localparam int WIDE_ITEMS  = 100;
	localparam int IDLE_PCT    = 35;
	localparam int HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES = 20;

	localparam cfg_idx_t              CFG_SPARE = cfg_idx_t'(3'd6);
	localparam logic [WEIGHT_W-1:0]   W_MAX     = 18'h1FFFF;
	localparam logic [WEIGHT_W-1:0]   W_MIN     = 18'h20000;

	logic clk        = 1'b0;
	logic arst_n     = 1'b0;
	logic src_gaps   = 1'b1;
	logic sink_gaps  = 1'b1;
	logic sink_hold  = 1'b0;
	int   mismatches = 0;

	cv3_pix_if pix_ch ();
	cv3_res_if res_ch ();
	cv3_cfg_if cfg_ch ();

	conv3x3_image_filter_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// Predictor copy of the filter state and registers
	logic [PIX_W-1:0]     line_mem [2*MAX_W];
	logic [PIX_W-1:0]     win [KK];
	logic [ROW_W-1:0]     row_pos;
	logic [COL_OUT_W-1:0] col_pos;
	logic [WROW_W-1:0]    krow [KSIZE];
	logic [LW_W-1:0]      lw_reg;
	logic [FH_W-1:0]      fh_reg;
	ovf_mode_t            ovf_reg;
	result_t              filtered_q [$];
	result_t              want;

	always #4 clk = ~clk;

	function automatic result_t filter_step(input logic [PIX_W-1:0] px, input logic fs);
		int unsigned w, h, col;
		int r, c, i;
		longint acc, mag, q;
		logic signed [WEIGHT_W-1:0] wt;
		result_t res;
		w = (lw_reg < 3) ? 3 : (lw_reg > MAX_W) ? MAX_W : lw_reg;
		h = (fh_reg < 3) ? 3 : (fh_reg > MAX_HEIGHT) ? MAX_HEIGHT : fh_reg;
		if (fs) begin
			row_pos = '0;
			col_pos = '0;
		end
		col = col_pos;
		for (r = 0; r < KSIZE; r++)
			for (c = 0; c < KSIZE - 1; c++)
				win[r*KSIZE + c] = win[r*KSIZE + c + 1];
		win[KSIZE-1]          = line_mem[MAX_W + col];
		win[2*KSIZE-1]        = line_mem[col];
		win[KK-1]             = px;
		line_mem[MAX_W + col] = line_mem[col];
		line_mem[col]         = px;
		res = '0;
		res.vres = row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w;
		if (res.vres) begin
			acc = 0;
			for (i = 0; i < KK; i++) begin
				wt = krow[i / KSIZE][WEIGHT_W*(i % KSIZE) +: WEIGHT_W];
				acc += longint'(wt) * longint'(win[i]);
			end
			// truncate toward zero on the magnitude
			mag = (acc < 0) ? -acc : acc;
			mag = mag >> FRAC;
			if (ovf_reg == OVF_WRAP)
				q = (acc < 0) ? -mag : mag;
			else
				q = (acc < 0) ? 0 : (mag > PIX_MAX) ? PIX_MAX : mag;
			res.pix = q[PIX_W-1:0];
		end
		res.crow = (row_pos > 0) ? row_pos - 1'b1 : '0;
		res.ccol = (col_pos > 0) ? col_pos - 1'b1 : '0;
		if (col_pos + 1 >= w) begin
			col_pos = '0;
			row_pos = (row_pos + 1 >= h) ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return res;
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		int v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = int'($urandom_range(16384)) - 8192;
			2: v = 0;
			default: v = $urandom_range(1) ? W_MAX : W_MIN;
		endcase
		return v[WEIGHT_W-1:0];
	endfunction

	function automatic logic [WROW_W-1:0] rand_row();
		return {rand_weight(), rand_weight(), rand_weight()};
	endfunction

	// Fill the bits above the register width with noise
	function automatic logic [WROW_W-1:0] junk_above(input logic [WROW_W-1:0] v, input int keep);
		logic [WROW_W-1:0] j;
		j = {$urandom, $urandom};
		return (j << keep) | v;
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel       <= px;
		pix_ch.frame_start <= fs;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		filtered_q.push_back(filter_step(px, fs));
	endtask

	// Drop the pixel stream and wait until every pending result has come back
	task automatic settle();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (filtered_q.size() != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [WROW_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_ROW0, CFG_ROW1, CFG_ROW2: krow[idx] = val;
			CFG_WIDTH:    lw_reg  = val[LW_W-1:0];
			CFG_HEIGHT:   fh_reg  = val[FH_W-1:0];
			CFG_OVF_MODE: ovf_reg = ovf_mode_t'(val[0]);
			default: ;
		endcase
	endtask

	task automatic set_filter(input logic [WROW_W-1:0] r0, r1, r2, lw, fh, mode);
		settle();
		write_reg(CFG_ROW0, r0);
		write_reg(CFG_ROW1, r1);
		write_reg(CFG_ROW2, r2);
		write_reg(CFG_WIDTH, lw);
		write_reg(CFG_HEIGHT, fh);
		write_reg(CFG_OVF_MODE, mode);
		cfg_ch.valid <= 1'b0;
	endtask

	// Check each result transaction and drive the receiver's ready
	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: result with none pending, expected nothing, got pixel %0d row %0d col %0d",
					$time, res_ch.filtered_pixel, res_ch.centre_row, res_ch.centre_col);
				mismatches++;
			end else begin
				want = filtered_q.pop_front();
				if (res_ch.filtered_pixel !== want.pix) begin
					$display("%0t: filtered_pixel expected %0d, got %0d",
						$time, want.pix, res_ch.filtered_pixel);
					mismatches++;
				end
				if (res_ch.valid_res !== want.vres) begin
					$display("%0t: valid_res expected %0d, got %0d",
						$time, want.vres, res_ch.valid_res);
					mismatches++;
				end
				if (res_ch.centre_row !== want.crow) begin
					$display("%0t: centre_row expected %0d, got %0d",
						$time, want.crow, res_ch.centre_row);
					mismatches++;
				end
				if (res_ch.centre_col !== want.ccol) begin
					$display("%0t: centre_col expected %0d, got %0d",
						$time, want.ccol, res_ch.centre_col);
					mismatches++;
				end
			end
		end
		res_ch.ready <= !sink_hold && (!sink_gaps || $urandom_range(99) >= IDLE_PCT);
	end

	task automatic test_reset_defaults();
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel($urandom_range(255), 1'b0);
	endtask

	task automatic test_extremes();
		int i;
		settle();
		// an unused register index must change nothing
		write_reg(CFG_SPARE, {WROW_W{1'b1}});
		cfg_ch.valid <= 1'b0;
		set_filter({3{W_MAX}}, {3{W_MAX}}, {3{W_MAX}}, 54'd3, 54'd3, OVF_CLAMP);
		for (i = 0; i < 9; i++)
			send_pixel(8'hFF, i == 0);
		// sizes below the minimum saturate to three
		set_filter({3{W_MIN}}, {3{W_MIN}}, {3{W_MIN}}, 54'd0, 54'd2, OVF_WRAP);
		for (i = 0; i < 9; i++)
			send_pixel(8'hFF, i == 0);
	endtask

	task automatic test_resize_mid_frame();
		int i;
		set_filter(rand_row(), rand_row(), rand_row(), 54'd4, 54'd5, OVF_CLAMP);
		for (i = 0; i < 11; i++)
			send_pixel($urandom_range(255), i == 0);
		// column now lies past the new width: invalid, then wrap
		set_filter(rand_row(), rand_row(), rand_row(), 54'd3, 54'd3, OVF_WRAP);
		for (i = 0; i < 3; i++)
			send_pixel($urandom_range(255), 1'b0);
	endtask

	task automatic test_backpressure();
		int i;
		set_filter(rand_row(), rand_row(), rand_row(), 54'd6, 54'd5, $urandom_range(1));
		src_gaps = 1'b0;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
			for (i = 0; i < 60; i++)
				send_pixel($urandom_range(255), i % 30 == 0);
		join
		src_gaps = 1'b1;
	endtask

	task automatic test_wide_line();
		int i;
		// oversize geometry saturates to the widest line and tallest frame
		set_filter(rand_row(), rand_row(), rand_row(), 54'd4095, 54'd8191, OVF_WRAP);
		src_gaps = 1'b0;
		sink_gaps <= 1'b0;
		for (i = 0; i < WIDE_ITEMS; i++)
			send_pixel($urandom_range(255), i == 0);
		src_gaps = 1'b1;
		sink_gaps <= 1'b1;
	endtask

	task automatic test_random_frames();
		int unsigned fed, w, h, frame, n, i;
		logic [WROW_W-1:0] lw, fh;
		logic clean_start, fs;
		logic [PIX_W-1:0] px;
		fed = 0;
		while (fed < RAND_ITEMS) begin
			w  = $urandom_range(3, 12);
			h  = $urandom_range(3, 7);
			lw = w;
			fh = h;
			if ($urandom_range(7) == 0) begin
				lw = $urandom_range(2);
				w  = 3;
			end
			if ($urandom_range(7) == 0) begin
				fh = $urandom_range(2);
				h  = 3;
			end
			set_filter(rand_row(), rand_row(), rand_row(), junk_above(lw, LW_W),
				junk_above(fh, FH_W), junk_above($urandom_range(1), 1));
			frame = w * h;
			n = frame * $urandom_range(1, 2) + $urandom_range(w);
			// a missing frame start carries the old counters into the new geometry
			clean_start = ($urandom_range(4) != 0);
			for (i = 0; i < n; i++) begin
				if (i % frame == 0)
					fs = (i != 0) || clean_start;
				else
					fs = ($urandom_range(49) == 0);
				px = ($urandom_range(3) == 0) ? {PIX_W{$urandom_range(1) == 1}}
					: $urandom_range(255);
				send_pixel(px, fs);
			end
			fed += n;
		end
	endtask

	initial begin
		pix_ch.valid       = 1'b0;
		pix_ch.pixel       = '0;
		pix_ch.frame_start = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_ROW0;
		cfg_ch.data        = '0;
		res_ch.ready       = 1'b0;
		foreach (line_mem[k])
			line_mem[k] = '0;
		foreach (win[k])
			win[k] = '0;
		row_pos = '0;
		col_pos = '0;
		krow[0] = ROW0_RESET;
		krow[1] = ROW1_RESET;
		krow[2] = ROW2_RESET;
		lw_reg  = LW_RESET;
		fh_reg  = FH_RESET;
		ovf_reg = OVF_CLAMP;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_extremes();
		test_resize_mid_frame();
		test_backpressure();
		test_wide_line();
		test_random_frames();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && filtered_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3_200_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
